[rtl/tagged_value_deframer_core_macros.svh]
// Assertion macros used by the deframer parser RTL.
`ifndef TAGGED_VALUE_DEFRAMER_CORE_MACROS_SVH
`define TAGGED_VALUE_DEFRAMER_CORE_MACROS_SVH
`ifndef SYNTH
`define TVD_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("deframer assertion failed");
`define TVD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deframer assertion failed");
`else
`define TVD_ASSERT(label, clk, rst_n, prop)
`define TVD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/tvd_pkg.sv]
`timescale 1ns / 1ps
package tvd_pkg;

	localparam int unsigned SHORT_SIZE = 4;
	localparam int unsigned LONG_SIZE  = 8;

	localparam int unsigned NUM_REGS  = 6;
	localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);

	localparam logic [REG_IDX_W-1:0] REG_INT32   = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_BOOLEAN = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_INT64   = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_DOUBLE  = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_TEXT    = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_BLOB    = REG_IDX_W'(5);

	typedef enum logic [2:0] {
		PH_TAG,
		PH_SHORT,
		PH_LONG,
		PH_LENGTH,
		PH_PAYLOAD
	} phase_t;

	typedef enum logic [1:0] {
		KIND_SCALAR,
		KIND_PAYLOAD,
		KIND_EMPTY,
		KIND_ERROR
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_UNKNOWN_TAG,
		ERR_TRUNCATED
	} err_t;

	typedef struct packed {
		logic [7:0] int32;
		logic [7:0] boolean;
		logic [7:0] int64;
		logic [7:0] dbl;
		logic [7:0] text;
		logic [7:0] blob;
	} tvd_codes_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  tag;
		logic [63:0] bits;
		logic [7:0]  pbyte;
		logic        last;
		logic [31:0] dlen;
		err_t        ecode;
	} tvd_result_t;

	// First match wins when several registers hold the same code.
	function automatic phase_t tag_phase(logic [7:0] b, tvd_codes_t c);
		phase_t ph;
		if (b == c.int32 || b == c.boolean) begin
			ph = PH_SHORT;
		end else if (b == c.int64 || b == c.dbl) begin
			ph = PH_LONG;
		end else if (b == c.text || b == c.blob) begin
			ph = PH_LENGTH;
		end else begin
			ph = PH_TAG;
		end
		return ph;
	endfunction

endpackage

[rtl/tvd_cfg_regs.sv]
`timescale 1ns / 1ps
module tvd_cfg_regs
	import tvd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output tvd_codes_t           codes
);

	tvd_codes_t codes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.int32   <= 8'd0;
			codes_q.boolean <= 8'd1;
			codes_q.int64   <= 8'd2;
			codes_q.dbl     <= 8'd3;
			codes_q.text    <= 8'd4;
			codes_q.blob    <= 8'd5;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INT32:   codes_q.int32   <= cfg_data;
				REG_BOOLEAN: codes_q.boolean <= cfg_data;
				REG_INT64:   codes_q.int64   <= cfg_data;
				REG_DOUBLE:  codes_q.dbl     <= cfg_data;
				REG_TEXT:    codes_q.text    <= cfg_data;
				REG_BLOB:    codes_q.blob    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign codes = codes_q;

endmodule

[rtl/tvd_parse.sv]
`timescale 1ns / 1ps
`include "tagged_value_deframer_core_macros.svh"
module tvd_parse
	import tvd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	input  logic        buffer_end,
	input  tvd_codes_t  codes,
	output logic        push,
	output tvd_result_t res
);

	phase_t      phase_q, phase_n;
	logic [7:0]  tag_q, tag_n;
	logic [2:0]  idx_q, idx_n;
	logic [63:0] asm_q, asm_n;
	logic [31:0] rem_q, rem_n;
	logic        sticky_q, sticky_n;
	logic        res_valid;
	logic        done;
	logic        field_done;
	logic        pay_last;

	always_comb begin
		phase_n    = phase_q;
		tag_n      = tag_q;
		idx_n      = idx_q;
		asm_n      = asm_q;
		rem_n      = rem_q;
		sticky_n   = sticky_q;
		res        = '0;
		res_valid  = 1'b0;
		done       = 1'b0;
		field_done = 1'b0;
		pay_last   = 1'b0;
		if (sticky_q) begin
			// After an error everything up to and including the final byte is dropped.
			if (buffer_end) begin
				phase_n  = PH_TAG;
				tag_n    = '0;
				idx_n    = '0;
				asm_n    = '0;
				rem_n    = '0;
				sticky_n = 1'b0;
			end
		end else begin
			case (phase_q)
				PH_TAG: begin
					tag_n   = data_byte;
					idx_n   = '0;
					asm_n   = '0;
					rem_n   = '0;
					phase_n = tag_phase(data_byte, codes);
					if (phase_n == PH_TAG) begin
						res.kind  = KIND_ERROR;
						res.tag   = data_byte;
						res.ecode = ERR_UNKNOWN_TAG;
						res_valid = 1'b1;
						sticky_n  = 1'b1;
						done      = 1'b1;
					end
				end
				PH_SHORT, PH_LONG, PH_LENGTH: begin
					asm_n[{idx_q, 3'b000} +: 8] = data_byte;
					field_done = (phase_q == PH_LONG) ? (idx_q == 3'(LONG_SIZE - 1))
						: (idx_q == 3'(SHORT_SIZE - 1));
					if (field_done) begin
						idx_n = '0;
						if (phase_q == PH_LENGTH) begin
							rem_n = asm_n[31:0];
							if (asm_n[31:0] == 32'd0) begin
								res.kind  = KIND_EMPTY;
								res.tag   = tag_q;
								res_valid = 1'b1;
								done      = 1'b1;
								phase_n   = PH_TAG;
							end else begin
								phase_n = PH_PAYLOAD;
							end
						end else begin
							res.kind  = KIND_SCALAR;
							res.tag   = tag_q;
							res.bits  = asm_n;
							res_valid = 1'b1;
							done      = 1'b1;
							phase_n   = PH_TAG;
						end
					end else begin
						idx_n = idx_q + 3'd1;
					end
				end
				default: begin
					pay_last = (rem_q <= 32'd1);
					// A payload byte that ends the buffer early reports the error instead.
					if (!(buffer_end && !pay_last)) begin
						rem_n     = pay_last ? 32'd0 : rem_q - 32'd1;
						res.kind  = KIND_PAYLOAD;
						res.tag   = tag_q;
						res.pbyte = data_byte;
						res.last  = pay_last;
						res.dlen  = asm_q[31:0];
						res_valid = 1'b1;
						if (pay_last) begin
							done    = 1'b1;
							phase_n = PH_TAG;
						end
					end
				end
			endcase
			if (buffer_end) begin
				if (!done) begin
					res       = '0;
					res.kind  = KIND_ERROR;
					res.tag   = tag_n;
					res.ecode = ERR_TRUNCATED;
					res_valid = 1'b1;
				end
				phase_n  = PH_TAG;
				tag_n    = '0;
				idx_n    = '0;
				asm_n    = '0;
				rem_n    = '0;
				sticky_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TAG;
			tag_q    <= '0;
			idx_q    <= '0;
			asm_q    <= '0;
			rem_q    <= '0;
			sticky_q <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_n;
			tag_q    <= tag_n;
			idx_q    <= idx_n;
			asm_q    <= asm_n;
			rem_q    <= rem_n;
			sticky_q <= sticky_n;
		end
	end

	assign push = accept && res_valid;

	`TVD_ASSERT_IMPL(a_sticky_waits_tag, clk, arst_n, sticky_q, phase_q == PH_TAG)
	`TVD_ASSERT_IMPL(a_payload_has_bytes, clk, arst_n, phase_q == PH_PAYLOAD, rem_q != 32'd0)
	`TVD_ASSERT_IMPL(a_index_in_field, clk, arst_n, idx_q != 3'd0,
		phase_q == PH_SHORT || phase_q == PH_LONG || phase_q == PH_LENGTH)
	`TVD_ASSERT(a_short_index, clk, arst_n, !(phase_q == PH_SHORT && idx_q > 3'(SHORT_SIZE - 1)))

endmodule

[rtl/tvd_out_queue.sv]
`timescale 1ns / 1ps
module tvd_out_queue
	import tvd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  tvd_result_t push_res,
	output logic        full,
	output logic        head_valid,
	input  logic        head_stall,
	output tvd_result_t head_res
);

	// Head register feeds the outputs; the skid entry catches one request
	// while the head is held by the downstream stall.
	tvd_result_t head_q, skid_q;
	logic        head_v_q, skid_v_q;
	logic        pop;

	assign pop  = head_v_q && !head_stall;
	assign full = head_v_q && skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (pop) begin
				head_v_q <= skid_v_q || push;
				skid_v_q <= skid_v_q && push;
			end else if (!head_v_q) begin
				head_v_q <= push;
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				head_q <= skid_q;
				if (push) begin
					skid_q <= push_res;
				end
			end else if (push) begin
				head_q <= push_res;
			end
		end else if (!head_v_q) begin
			if (push) begin
				head_q <= push_res;
			end
		end else if (push) begin
			skid_q <= push_res;
		end
	end

	assign head_valid = head_v_q;
	assign head_res   = head_q;

endmodule

[rtl/tagged_value_deframer_core.sv]
// Each result is registered in the head entry that drives the result port, or in the skid entry.
// Throughput: one byte per cycle while item_stall is low; the parse state is updated in a single pass per byte.
// A two-entry result register keeps bytes flowing while one result waits on stall.
// Reset clears the parse state and the result queue, and sets the tag codes to 0..5.
`timescale 1ns / 1ps
module tagged_value_deframer_core
	import tvd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [7:0]           data_byte,
	input  logic                 buffer_end,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [1:0]           result_kind,
	output logic [7:0]           tag_code,
	output logic [63:0]          scalar_bits,
	output logic [7:0]           payload_byte,
	output logic                 payload_last,
	output logic [31:0]          declared_length,
	output logic [1:0]           error_code
);

	tvd_codes_t  codes;
	tvd_result_t step_res;
	tvd_result_t head_res;
	logic        accept;
	logic        push;
	logic        full;

	assign item_stall = full;
	assign accept     = item_valid && !item_stall;

	tvd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.codes     (codes)
	);

	tvd_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (data_byte),
		.buffer_end (buffer_end),
		.codes      (codes),
		.push       (push),
		.res        (step_res)
	);

	tvd_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_res   (step_res),
		.full       (full),
		.head_valid (result_valid),
		.head_stall (result_stall),
		.head_res   (head_res)
	);

	assign result_kind     = head_res.kind;
	assign tag_code        = head_res.tag;
	assign scalar_bits     = head_res.bits;
	assign payload_byte    = head_res.pbyte;
	assign payload_last    = head_res.last;
	assign declared_length = head_res.dlen;
	assign error_code      = head_res.ecode;

endmodule
